>>> rtl/pcq_pkg.sv
// shared types, constants and pointer helpers for the priority command queue
package pcq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = 4;

    localparam logic [31:0] MAX_AGE_RST = 32'd100;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_DEQ   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_CLEAN = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic [2:0]  operation;
        logic        cmd_is_stop;
        logic [31:0] cmd_payload;
        logic [31:0] cmd_time;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic              out_is_stop;
        logic [31:0]       out_payload;
        logic [31:0]       out_time;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
        logic              is_full;
    } t_resp;

    typedef struct packed {
        logic        stop;
        logic [31:0] payload;
        logic [31:0] tstamp;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_ptr   addr;
        t_entry data;
    } t_wr_port;

    typedef struct packed {
        logic en;
        t_ptr addr;
    } t_rd_port;

    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        if (p == '0) begin
            return t_ptr'(DEPTH - 1);
        end
        return p - t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_fill(input t_ptr wp, input t_ptr rp);
        logic [PTR_W:0] d;
        d = {1'b0, wp} - {1'b0, rp};
        if (wp < rp) begin
            d = d + (PTR_W + 1)'(DEPTH);
        end
        return d[PTR_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] fill_field(input t_ptr f);
        logic [31:0] w;
        w = 32'(f);
        return w[FILL_W-1:0];
    endfunction

endpackage

>>> rtl/priority_command_queue_top.sv
// priority command queue top level: config register, sequencer, storage, age compare
// Enqueue into a non-full queue, a refused enqueue, clear or an unused code, and dequeue,
// peek or cleanup on an empty queue go straight from idle to the result state. Dequeue
// and cleanup examine front entries one by one and peek only the front one; each look
// at an entry is a registered read of the single storage read port followed by the age
// compare. A stop command into a full queue scans for the oldest non-stop entry and then
// moves the entries behind it up one by one in the close-up. A finished result sits in an
// output register, so the next request is taken while it waits. max_age may be written
// at any time the queue is idle (ready always high).
module priority_command_queue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  pcq_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output pcq_pkg::t_resp o_resp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [31:0]    i_cfg_data
);

    logic [31:0]       r_max_age;
    pcq_pkg::t_wr_port wr;
    pcq_pkg::t_rd_port rd;
    pcq_pkg::t_entry   rd_data;
    logic              stale;
    logic [31:0]       age_now;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= pcq_pkg::MAX_AGE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_age <= i_cfg_data;
        end
    end

    pcq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    pcq_age_cmp u_age (
        .i_now     (age_now),
        .i_tstamp  (rd_data.tstamp),
        .i_max_age (r_max_age),
        .o_stale   (stale)
    );

    pcq_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp),
        .o_wr         (wr),
        .o_rd         (rd),
        .i_rd_data    (rd_data),
        .i_stale      (stale),
        .o_age_now    (age_now)
    );

endmodule

>>> rtl/pcq_store.sv
// entry storage: one write port, one registered read port
module pcq_store (
    input  logic              i_clk,
    input  pcq_pkg::t_wr_port i_wr,
    input  pcq_pkg::t_rd_port i_rd,
    output pcq_pkg::t_entry   o_rd_data
);

    pcq_pkg::t_entry r_mem [pcq_pkg::DEPTH];
    pcq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/pcq_age_cmp.sv
// shared staleness compare: modular age against the configured limit
module pcq_age_cmp (
    input  logic [31:0] i_now,
    input  logic [31:0] i_tstamp,
    input  logic [31:0] i_max_age,
    output logic        o_stale
);

    logic [31:0] age;

    assign age     = i_now - i_tstamp;
    assign o_stale = age > i_max_age;

endmodule

>>> rtl/pcq_seq.sv
// queue sequencer: pointers, scan / close-up / stale walk, result register
module pcq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  pcq_pkg::t_req     i_req,
    output logic              o_resp_valid,
    input  logic              i_resp_ready,
    output pcq_pkg::t_resp    o_resp,
    output pcq_pkg::t_wr_port o_wr,
    output pcq_pkg::t_rd_port o_rd,
    input  pcq_pkg::t_entry   i_rd_data,
    input  logic              i_stale,
    output logic [31:0]       o_age_now
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FRONT_RD  = 8'b0000_0010,
        S_FRONT_CHK = 8'b0000_0100,
        S_SCAN_RD   = 8'b0000_1000,
        S_SCAN_CHK  = 8'b0001_0000,
        S_SHIFT_RD  = 8'b0010_0000,
        S_SHIFT_WR  = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    pcq_pkg::t_req   r_req, n_req;
    pcq_pkg::t_ptr   r_wp, n_wp;
    pcq_pkg::t_ptr   r_rp, n_rp;
    pcq_pkg::t_ptr   r_idx, n_idx;
    logic            r_ok, n_ok;
    pcq_pkg::t_entry r_hit, n_hit;
    logic            r_out_valid, n_out_valid;
    pcq_pkg::t_resp  r_out, n_out;

    pcq_pkg::t_entry in_ent;
    pcq_pkg::t_entry held_ent;
    pcq_pkg::t_ptr   fill;
    logic            full;
    logic            empty;
    logic            acc;

    assign o_req_ready  = (r_state == S_IDLE);
    assign acc          = i_req_valid && o_req_ready;
    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;
    assign o_age_now    = r_req.now_time;

    assign full  = (pcq_pkg::ptr_inc(r_wp) == r_rp);
    assign empty = (r_wp == r_rp);
    assign fill  = pcq_pkg::ptr_fill(r_wp, r_rp);

    always_comb begin
        in_ent.stop      = i_req.cmd_is_stop;
        in_ent.payload   = i_req.cmd_payload;
        in_ent.tstamp    = i_req.cmd_time;
        held_ent.stop    = r_req.cmd_is_stop;
        held_ent.payload = r_req.cmd_payload;
        held_ent.tstamp  = r_req.cmd_time;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_hit       = r_hit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_resp_ready;
        o_wr        = '0;
        o_rd        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_req   = i_req;
                    n_ok    = 1'b0;
                    n_hit   = '0;
                    n_state = S_DONE;
                    unique case (i_req.operation) inside
                        pcq_pkg::OP_ENQ: begin
                            if (!i_req.cmd_is_stop) begin
                                if (!full) begin
                                    o_wr.en   = 1'b1;
                                    o_wr.addr = r_wp;
                                    o_wr.data = in_ent;
                                    n_wp      = pcq_pkg::ptr_inc(r_wp);
                                    n_ok      = 1'b1;
                                end
                            end else if (!full) begin
                                o_wr.en   = 1'b1;
                                o_wr.addr = pcq_pkg::ptr_dec(r_rp);
                                o_wr.data = in_ent;
                                n_rp      = pcq_pkg::ptr_dec(r_rp);
                                n_ok      = 1'b1;
                            end else begin
                                // full: look for the oldest non-stop entry
                                n_idx   = r_rp;
                                n_state = S_SCAN_RD;
                            end
                        end
                        pcq_pkg::OP_DEQ, pcq_pkg::OP_PEEK, pcq_pkg::OP_CLEAN: begin
                            if (!empty) begin
                                n_state = S_FRONT_RD;
                            end
                        end
                        pcq_pkg::OP_CLEAR: begin
                            n_wp = '0;
                            n_rp = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FRONT_RD: begin
                o_rd.en   = 1'b1;
                o_rd.addr = r_rp;
                n_state   = S_FRONT_CHK;
            end
            S_FRONT_CHK: begin
                if (r_req.operation == pcq_pkg::OP_PEEK) begin
                    n_ok    = 1'b1;
                    n_hit   = i_rd_data;
                    n_state = S_DONE;
                end else if (i_stale) begin
                    n_rp = pcq_pkg::ptr_inc(r_rp);
                    if (pcq_pkg::ptr_inc(r_rp) == r_wp) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FRONT_RD;
                    end
                end else begin
                    if (r_req.operation == pcq_pkg::OP_DEQ) begin
                        n_ok  = 1'b1;
                        n_hit = i_rd_data;
                        n_rp  = pcq_pkg::ptr_inc(r_rp);
                    end
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_wp) begin
                    // all stops: replace the front entry
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_rp;
                    o_wr.data = held_ent;
                    n_ok      = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = r_idx;
                    n_state   = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_rd_data.stop) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_idx   = pcq_pkg::ptr_inc(r_idx);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (pcq_pkg::ptr_inc(r_idx) == r_wp) begin
                    // close-up done: drop the tail slot and put the stop at the front
                    n_wp      = pcq_pkg::ptr_dec(r_wp);
                    n_rp      = pcq_pkg::ptr_dec(r_rp);
                    o_wr.en   = 1'b1;
                    o_wr.addr = pcq_pkg::ptr_dec(r_rp);
                    o_wr.data = held_ent;
                    n_ok      = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = pcq_pkg::ptr_inc(r_idx);
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_idx;
                o_wr.data = i_rd_data;
                n_idx     = pcq_pkg::ptr_inc(r_idx);
                n_state   = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_resp_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.ok          = r_ok;
                    n_out.out_is_stop = r_hit.stop;
                    n_out.out_payload = r_hit.payload;
                    n_out.out_time    = r_hit.tstamp;
                    n_out.fill_count  = pcq_pkg::fill_field(fill);
                    n_out.is_empty    = (fill == '0);
                    n_out.is_full     = (fill == pcq_pkg::t_ptr'(pcq_pkg::DEPTH - 1));
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_ok  <= n_ok;
        r_hit <= n_hit;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.operation == pcq_pkg::OP_ENQ && !i_req.cmd_is_stop && !full)
        |=> (fill == $past(fill) + pcq_pkg::t_ptr'(1)))
        else $error("normal enqueue did not grow the queue by one");

    a_clear_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.operation == pcq_pkg::OP_CLEAR) |=> (r_wp == '0 && r_rp == '0))
        else $error("clear left pointers nonzero");

    a_scan_holds_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |=> ($stable(r_wp) && $stable(r_rp)))
        else $error("pointers moved during stop scan");

    a_no_write_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> !(r_state == S_FRONT_CHK || r_state == S_SCAN_CHK || r_state == S_DONE))
        else $error("store written in a check or result state");
`endif

endmodule

>>> verif/priority_command_queue_top_tb.sv
// self-checking testbench for the priority command queue top level
`timescale 1ns / 1ps

module priority_command_queue_top_tb;

    import pcq_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = OP_CLEAN + 3'd1;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int unsigned PHASES = 12;
    localparam int unsigned ITEMS_PER_PHASE = 118;
    localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;

    typedef enum int unsigned {MODE_FILL, MODE_DRAIN, MODE_MIX} drive_mode_e;

    class cmd_queue_scoreboard;
        t_entry slot [DEPTH];
        int unsigned wr;
        int unsigned rd;
        logic [31:0] max_age;
        t_resp predicted_resp_q [$];
        int unsigned mismatches;

        function new();
            wr = 0;
            rd = 0;
            max_age = MAX_AGE_RST;
            mismatches = 0;
        endfunction

        function int unsigned nxt(int unsigned p);
            return (p + 1) % DEPTH;
        endfunction

        function int unsigned prv(int unsigned p);
            return (p + DEPTH - 1) % DEPTH;
        endfunction

        function void set_max_age(logic [31:0] v);
            max_age = v;
        endfunction

        function int unsigned pending();
            return predicted_resp_q.size();
        endfunction

        function bit is_stale(int unsigned p, logic [31:0] now);
            logic [31:0] age;
            age = now - slot[p].tstamp;
            return age > max_age;
        endfunction

        function void purge_stale(logic [31:0] now);
            while (rd != wr && is_stale(rd, now)) begin
                rd = nxt(rd);
            end
        endfunction

        function bit insert_cmd(t_req r);
            t_entry e;
            bit full;
            int unsigned i;
            e.stop = r.cmd_is_stop;
            e.payload = r.cmd_payload;
            e.tstamp = r.cmd_time;
            full = (nxt(wr) == rd);
            if (!r.cmd_is_stop) begin
                if (full) begin
                    return 1'b0;
                end
                slot[wr] = e;
                wr = nxt(wr);
                return 1'b1;
            end
            if (full) begin
                // look for the oldest normal command to evict
                i = rd;
                while (i != wr && slot[i].stop) begin
                    i = nxt(i);
                end
                if (i == wr) begin
                    slot[rd] = e;
                    return 1'b1;
                end
                while (nxt(i) != wr) begin
                    slot[i] = slot[nxt(i)];
                    i = nxt(i);
                end
                wr = prv(wr);
            end
            rd = prv(rd);
            slot[rd] = e;
            return 1'b1;
        endfunction

        function void note_request(t_req r);
            t_resp rsp;
            int unsigned n;
            rsp = '0;
            case (r.operation)
                OP_ENQ: begin
                    rsp.ok = insert_cmd(r);
                end
                OP_DEQ, OP_PEEK: begin
                    // peek leaves stale entries in place
                    if (r.operation == OP_DEQ) begin
                        purge_stale(r.now_time);
                    end
                    if (rd != wr) begin
                        rsp.ok = 1'b1;
                        rsp.out_is_stop = slot[rd].stop;
                        rsp.out_payload = slot[rd].payload;
                        rsp.out_time = slot[rd].tstamp;
                        if (r.operation == OP_DEQ) begin
                            rd = nxt(rd);
                        end
                    end
                end
                OP_CLEAR: begin
                    wr = 0;
                    rd = 0;
                end
                OP_CLEAN: begin
                    purge_stale(r.now_time);
                end
                default: begin
                end
            endcase
            n = (wr + DEPTH - rd) % DEPTH;
            rsp.fill_count = FILL_W'(n);
            rsp.is_empty = (n == 0);
            rsp.is_full = (n == DEPTH - 1);
            predicted_resp_q.push_back(rsp);
        endfunction

        function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_resp got);
            t_resp want;
            if (predicted_resp_q.size() == 0) begin
                $error("response with no request outstanding: %0h", got);
                mismatches++;
                return;
            end
            want = predicted_resp_q.pop_front();
            cmp_field("ok", want.ok, got.ok);
            cmp_field("out_is_stop", want.out_is_stop, got.out_is_stop);
            cmp_field("out_payload", want.out_payload, got.out_payload);
            cmp_field("out_time", want.out_time, got.out_time);
            cmp_field("fill_count", want.fill_count, got.fill_count);
            cmp_field("is_empty", want.is_empty, got.is_empty);
            cmp_field("is_full", want.is_full, got.is_full);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_resp_valid;
    logic        i_resp_ready;
    t_resp       o_resp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    cmd_queue_scoreboard sb;

    bit          send_idle_en;
    bit          resp_idle_en;
    int unsigned resp_hold;
    int unsigned stop_pct;
    int unsigned age_span;
    logic [31:0] tb_now;

    priority_command_queue_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 80) begin
            return $urandom_range(1, 3);
        end
        if (p < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // response side back-pressure
    always @(posedge i_clk) begin
        if (!resp_idle_en) begin
            i_resp_ready <= 1'b1;
        end else if (resp_hold != 0) begin
            i_resp_ready <= 1'b0;
            resp_hold <= resp_hold - 1;
        end else begin
            i_resp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                resp_hold <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            sb.check_response(o_resp);
        end
    end

    function automatic t_req mk_req(logic [2:0] op, logic stop, logic [31:0] pay,
                                    logic [31:0] tm, logic [31:0] now);
        t_req r;
        r.operation = op;
        r.cmd_is_stop = stop;
        r.cmd_payload = pay;
        r.cmd_time = tm;
        r.now_time = now;
        return r;
    endfunction

    function automatic logic [2:0] pick_op(drive_mode_e m);
        int unsigned p;
        p = $urandom_range(0, 99);
        case (m)
            MODE_FILL: begin
                if (p < 85) return OP_ENQ;
                if (p < 90) return OP_DEQ;
                if (p < 95) return OP_PEEK;
                return OP_CLEAN;
            end
            MODE_DRAIN: begin
                if (p < 20) return OP_ENQ;
                if (p < 75) return OP_DEQ;
                if (p < 90) return OP_PEEK;
                return OP_CLEAN;
            end
            default: begin
                if (p < 40) return OP_ENQ;
                if (p < 65) return OP_DEQ;
                if (p < 80) return OP_PEEK;
                if (p < 85) return OP_CLEAR;
                if (p < 92) return OP_CLEAN;
                return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end
        endcase
    endfunction

    function automatic t_req build_req(drive_mode_e m);
        t_req r;
        int unsigned p;
        // time mostly creeps forward, now and then it jumps anywhere
        if ($urandom_range(0, 149) == 0) begin
            tb_now = $urandom;
        end else begin
            tb_now = tb_now + $urandom_range(0, 3);
        end
        r.operation = pick_op(m);
        r.cmd_is_stop = ($urandom_range(0, 99) < stop_pct);
        r.cmd_payload = $urandom;
        p = $urandom_range(0, 99);
        if (p < 80) begin
            r.cmd_time = tb_now - $urandom_range(0, age_span);
        end else if (p < 90) begin
            r.cmd_time = tb_now + $urandom_range(1, 8);
        end else begin
            r.cmd_time = $urandom;
        end
        r.now_time = ($urandom_range(0, 19) == 0) ? $urandom : tb_now;
        return r;
    endfunction

    task automatic send_req(t_req r);
        int unsigned gap;
        i_req <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
        gap = (send_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_max_age(logic [31:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_max_age(v);
        // for a limit below 40 keep timestamp ages spanning the staleness threshold
        age_span = (v < 40) ? v + 8 : 48;
    endtask

    task automatic run_directed();
        // empty queue and unused codes
        send_req(mk_req(OP_DEQ, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_PEEK, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_CLEAR, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_CLEAN, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_UNUSED_LO, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(mk_req(OP_UNUSED_HI, 1'b0, 32'h0, 32'h0, 32'h0));
        // field extremes, stop goes to the front
        send_req(mk_req(OP_ENQ, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_ENQ, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(mk_req(OP_ENQ, 1'b1, 32'hA5A5_A5A5, 32'd5, 32'd5));
        send_req(mk_req(OP_PEEK, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_UNUSED_HI, 1'b0, 32'h0, 32'h0, 32'h0));
        // stop entry has wrapped age and is dropped before the dequeue returns
        send_req(mk_req(OP_DEQ, 1'b0, 32'h0, 32'h0, 32'h0));
        // peek returns a stale entry, cleanup then drops it
        send_req(mk_req(OP_PEEK, 1'b0, 32'h0, 32'h0, 32'd1000));
        send_req(mk_req(OP_CLEAN, 1'b0, 32'h0, 32'h0, 32'd1000));
        // age exactly at the limit is still fresh, one past is stale
        send_req(mk_req(OP_ENQ, 1'b1, 32'd1, 32'd50, 32'd50));
        send_req(mk_req(OP_ENQ, 1'b0, 32'd2, 32'd60, 32'd60));
        send_req(mk_req(OP_DEQ, 1'b0, 32'h0, 32'h0, 32'd150));
        send_req(mk_req(OP_DEQ, 1'b0, 32'h0, 32'h0, 32'd161));
        send_req(mk_req(OP_ENQ, 1'b0, 32'd3, 32'h0, 32'h0));
        send_req(mk_req(OP_CLEAR, 1'b0, 32'h0, 32'h0, 32'h0));
        send_req(mk_req(OP_PEEK, 1'b0, 32'h0, 32'h0, 32'h0));
    endtask

    initial begin
        #10_000_000;
        $display("FAIL priority_command_queue_top");
        $finish;
    end

    initial begin
        drive_mode_e mode;
        int unsigned left;
        int unsigned burst;
        logic [31:0] age_val;

        sb = new();
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_resp_ready <= 1'b0;
        resp_hold = 0;
        send_idle_en = 1'b1;
        resp_idle_en = 1'b1;
        stop_pct = 30;
        age_span = 48;
        tb_now = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            // every phase starts from a quiet block so max_age can change
            wait_drained();
            if (phase != 0) begin
                case (phase)
                    1: age_val = 32'h0;
                    2: age_val = 32'hFFFF_FFFF;
                    3: age_val = MAX_AGE_RST;
                    default: begin
                        case ($urandom_range(0, 2))
                            0: age_val = $urandom_range(1, 60);
                            1: age_val = $urandom_range(61, 500);
                            default: age_val = $urandom;
                        endcase
                    end
                endcase
                write_max_age(age_val);
            end
            resp_idle_en = (phase % 4 != 2);
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(8, 40);
                mode = drive_mode_e'($urandom_range(MODE_FILL, MODE_MIX));
                case ($urandom_range(0, 3))
                    0: stop_pct = 0;
                    1: stop_pct = 25;
                    2: stop_pct = 60;
                    default: stop_pct = 100;
                endcase
                send_idle_en = (phase % 4 != 2) && ($urandom_range(0, 3) != 0);
                for (int unsigned k = 0; k < burst && left > 0; k++) begin
                    send_req(build_req(mode));
                    left--;
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASS priority_command_queue_top");
        end else begin
            $display("FAIL priority_command_queue_top");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pcq_pkg.sv
rtl/pcq_store.sv
rtl/pcq_age_cmp.sv
rtl/pcq_seq.sv
rtl/priority_command_queue_top.sv
verif/priority_command_queue_top_tb.sv
